[src/cc20_pkg.sv]
`timescale 1ns / 1ps

package cc20_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int WORDS = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_01   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_23   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_45   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_67   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_01 = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_2  = 3'd5;

    typedef logic [31:0] word_t;
    typedef logic [WORDS-1:0][31:0] state_t;
    typedef logic [3:0][63:0] key_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    localparam word_t SIGMA_0 = 32'h61707865;
    localparam word_t SIGMA_1 = 32'h3320646e;
    localparam word_t SIGMA_2 = 32'h79622d32;
    localparam word_t SIGMA_3 = 32'h6b206574;

    function automatic word_t rotl(input word_t v, input logic [4:0] n);
        logic [63:0] t;
        t = {v, v} << n;
        return t[63:32];
    endfunction

    // one half of a quarter round: two add, xor, rotate steps
    function automatic quad_t qr_half(input quad_t q, input logic second);
        quad_t r;
        r = q;
        r.a = r.a + r.b;
        r.d = rotl(r.d ^ r.a, second ? 5'd8 : 5'd16);
        r.c = r.c + r.d;
        r.b = rotl(r.b ^ r.c, second ? 5'd7 : 5'd12);
        return r;
    endfunction

    function automatic state_t init_state(input key_t key, input logic [63:0] nonce01,
                                          input word_t nonce2, input word_t ctr);
        state_t s;
        s[0] = SIGMA_0;
        s[1] = SIGMA_1;
        s[2] = SIGMA_2;
        s[3] = SIGMA_3;
        for (int i = 0; i < 4; i++) begin
            s[4 + 2 * i] = key[i][31:0];
            s[5 + 2 * i] = key[i][63:32];
        end
        s[12] = ctr;
        s[13] = nonce01[31:0];
        s[14] = nonce01[63:32];
        s[15] = nonce2;
        return s;
    endfunction

endpackage

[src/chacha20_block_function.sv]
`timescale 1ns / 1ps

// chacha20 block function
// s_ channel: one item per block, s_tdata carries the 32-bit block counter.
// m_ channel: sixteen items per block in order, m_tdata carries the word
//   index and the keystream word, m_tlast marks the sixteenth word.
// cfg channel: cfg_index selects key words 0/1, 2/3, 4/5, 6/7, nonce words
//   0/1 and nonce word 2; writes to others are dropped. cfg_ready is always high.
//   the user must change configuration only while no block is in flight (unchecked).
// pipeline: 4 * DOUBLE_ROUNDS register stages, each half of a column or
//   diagonal round, followed by the feed-forward add into a 16-word output
//   shift buffer.
// flow: the one-word output channel sets the block rate; the pipeline itself
//   takes a counter every cycle unless stalled, and holds up to
//   4 * DOUBLE_ROUNDS blocks plus one in the output buffer.
// stalls: when m_tready is low the buffer holds its word, stages fill up
//   behind it and s_tready drops; nothing is lost or repeated.
// reset: clears all configuration registers to zero and empties the pipeline.

module chacha20_block_function import cc20_pkg::*; #(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // block_counter[31:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // word_index[3:0], keystream_word[35:4], zero
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int STAGES = 4 * DOUBLE_ROUNDS;

    key_t        key_reg;
    logic [63:0] nonce01_reg;
    word_t       nonce2_reg;

    logic   st_valid [STAGES+1];
    logic   st_ready [STAGES+1];
    state_t st_state [STAGES+1];
    word_t  st_ctr   [STAGES+1];

    state_t     final_words;
    state_t     orig_state;
    logic [3:0] word_index;
    word_t      keystream_word;
    logic       last_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg     <= '0;
            nonce01_reg <= '0;
            nonce2_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_KEY_01:   key_reg[0]  <= cfg_data;
                CFG_KEY_23:   key_reg[1]  <= cfg_data;
                CFG_KEY_45:   key_reg[2]  <= cfg_data;
                CFG_KEY_67:   key_reg[3]  <= cfg_data;
                CFG_NONCE_01: nonce01_reg <= cfg_data;
                CFG_NONCE_2:  nonce2_reg  <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign st_valid[0] = s_tvalid;
    assign s_tready    = st_ready[0];
    assign st_state[0] = init_state(key_reg, nonce01_reg, nonce2_reg, s_tdata);
    assign st_ctr[0]   = s_tdata;

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        cc20_qr_stage #(
            .DIAG   (1'((k / 2) % 2)),
            .SECOND (1'(k % 2))
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[k]),
            .in_ready  (st_ready[k]),
            .in_state  (st_state[k]),
            .in_ctr    (st_ctr[k]),
            .out_valid (st_valid[k+1]),
            .out_ready (st_ready[k+1]),
            .out_state (st_state[k+1]),
            .out_ctr   (st_ctr[k+1])
        );
    end

    // feed-forward add; the user must keep the key stable while the block is in flight, the block does not enforce it
    always_comb begin
        orig_state = init_state(key_reg, nonce01_reg, nonce2_reg, st_ctr[STAGES]);
        for (int i = 0; i < WORDS; i++) begin
            final_words[i] = st_state[STAGES][i] + orig_state[i];
        end
    end

    cc20_out_buffer u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (st_valid[STAGES]),
        .in_ready       (st_ready[STAGES]),
        .in_words       (final_words),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .word_index     (word_index),
        .keystream_word (keystream_word),
        .last_word      (last_word)
    );

    assign m_tdata = {4'd0, keystream_word, word_index};
    assign m_tlast = last_word;

endmodule

[src/cc20_qr_stage.sv]
`timescale 1ns / 1ps

module cc20_qr_stage import cc20_pkg::*; #(
    parameter bit DIAG = 1'b0,
    parameter bit SECOND = 1'b0
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  state_t in_state,
    input  word_t  in_ctr,
    output logic   out_valid,
    input  logic   out_ready,
    output state_t out_state,
    output word_t  out_ctr
);

    logic   valid_reg;
    state_t state_reg;
    word_t  ctr_reg;
    state_t state_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_ctr   = ctr_reg;

    always_comb begin
        quad_t      q;
        logic [3:0] ib;
        logic [3:0] ic;
        logic [3:0] id;
        state_next = in_state;
        for (int i = 0; i < 4; i++) begin
            ib = 4'(4 + ((i + int'(DIAG)) & 3));
            ic = 4'(8 + ((i + 2 * int'(DIAG)) & 3));
            id = 4'(12 + ((i + 3 * int'(DIAG)) & 3));
            q.a = in_state[i];
            q.b = in_state[ib];
            q.c = in_state[ic];
            q.d = in_state[id];
            q = qr_half(q, SECOND);
            state_next[i]  = q.a;
            state_next[ib] = q.b;
            state_next[ic] = q.c;
            state_next[id] = q.d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            state_reg <= state_next;
            ctr_reg   <= in_ctr;
        end
    end

endmodule

[src/cc20_out_buffer.sv]
`timescale 1ns / 1ps

module cc20_out_buffer import cc20_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  state_t     in_words,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [3:0] word_index,
    output word_t      keystream_word,
    output logic       last_word
);

    logic       valid_reg;
    logic [3:0] idx_reg;
    state_t     words_reg;
    logic       take;
    logic       load;

    assign take = valid_reg && m_tready;
    assign in_ready = !valid_reg || (take && idx_reg == 4'(WORDS - 1));
    assign load = in_ready && in_valid;

    assign m_tvalid       = valid_reg;
    assign word_index     = idx_reg;
    assign keystream_word = words_reg[0];
    assign last_word      = (idx_reg == 4'(WORDS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (take) begin
            if (idx_reg == 4'(WORDS - 1)) begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 4'd1;
        end
    end

    // shift so the current word always sits in slot zero
    always_ff @(posedge aclk) begin
        if (load) begin
            words_reg <= in_words;
        end else if (take) begin
            words_reg <= {32'd0, words_reg[WORDS-1:1]};
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import cc20_pkg::*;

    localparam int N_DOUBLE = 10;
    localparam int DRAIN_CYCLES = 4 * N_DOUBLE + 24;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam word_t CHACHA_C0 = 32'h61707865;
    localparam word_t CHACHA_C1 = 32'h3320646e;
    localparam word_t CHACHA_C2 = 32'h79622d32;
    localparam word_t CHACHA_C3 = 32'h6b206574;

    typedef struct packed {
        logic [3:0] idx;
        word_t      word;
        logic       last;
    } ks_word_t;

    typedef enum int {RX_FREE, RX_COIN, RX_HOLD, RX_MOSTLY} rx_mode_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic [63:0] key_reg [4] = '{default: '0};
    logic [63:0] nonce01_reg = '0;
    word_t       nonce2_reg = '0;

    word_t    counter_q [$];
    ks_word_t keystream_q [$];

    bit       s_hs, m_hs, cfg_hs;
    int       idle_cycles = 0;
    int       errors = 0;
    int       blocks_sent = 0;
    int       words_checked = 0;
    int       cfg_writes = 0;
    int       burst_left = 1;
    int       gap_left = 0;
    int       rdy_left = 0;
    rx_mode_t rdy_mode = RX_FREE;

    chacha20_block_function #(
        .DOUBLE_ROUNDS(N_DOUBLE)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic word_t rol32(input word_t v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void quarter_mix(inout state_t x, input int a, input int b,
                                        input int c, input int d);
        x[a] = x[a] + x[b]; x[d] = rol32(x[d] ^ x[a], 16);
        x[c] = x[c] + x[d]; x[b] = rol32(x[b] ^ x[c], 12);
        x[a] = x[a] + x[b]; x[d] = rol32(x[d] ^ x[a], 8);
        x[c] = x[c] + x[d]; x[b] = rol32(x[b] ^ x[c], 7);
    endfunction

    function automatic state_t keystream_block(input word_t ctr);
        state_t init, x;
        int     i;
        init[0] = CHACHA_C0;
        init[1] = CHACHA_C1;
        init[2] = CHACHA_C2;
        init[3] = CHACHA_C3;
        for (i = 0; i < 4; i++) begin
            init[4 + 2 * i] = key_reg[i][31:0];
            init[5 + 2 * i] = key_reg[i][63:32];
        end
        init[12] = ctr;
        init[13] = nonce01_reg[31:0];
        init[14] = nonce01_reg[63:32];
        init[15] = nonce2_reg;
        x = init;
        for (i = 0; i < N_DOUBLE; i++) begin
            quarter_mix(x, 0, 4, 8, 12);
            quarter_mix(x, 1, 5, 9, 13);
            quarter_mix(x, 2, 6, 10, 14);
            quarter_mix(x, 3, 7, 11, 15);
            quarter_mix(x, 0, 5, 10, 15);
            quarter_mix(x, 1, 6, 11, 12);
            quarter_mix(x, 2, 7, 8, 13);
            quarter_mix(x, 3, 4, 9, 14);
        end
        for (i = 0; i < WORDS; i++)
            x[i] = x[i] + init[i];
        return x;
    endfunction

    function automatic void apply_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [63:0] data);
        case (idx)
            CFG_KEY_01:   key_reg[0] = data;
            CFG_KEY_23:   key_reg[1] = data;
            CFG_KEY_45:   key_reg[2] = data;
            CFG_KEY_67:   key_reg[3] = data;
            CFG_NONCE_01: nonce01_reg = data;
            CFG_NONCE_2:  nonce2_reg = data[31:0];
            default:      ;
        endcase
    endfunction

    function automatic logic [63:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic word_t pick_counter();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1;
            3:       return 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (counter_q.size() != 0 || s_tvalid || keystream_q.size() != 0)
            @(posedge aclk);
    endtask

    // prediction, checking and watchdog
    always @(posedge aclk) begin
        state_t   blk;
        ks_word_t exp_w;
        int       i;
        s_hs   = aresetn && s_tvalid && s_tready;
        m_hs   = aresetn && m_tvalid && m_tready;
        cfg_hs = aresetn && cfg_valid && cfg_ready;
        if (cfg_hs) begin
            apply_cfg(cfg_index, cfg_data);
            cfg_writes++;
        end
        if (s_hs) begin
            blk = keystream_block(s_tdata);
            for (i = 0; i < WORDS; i++) begin
                exp_w.idx  = 4'(i);
                exp_w.word = blk[i];
                exp_w.last = (i == WORDS - 1);
                keystream_q.push_back(exp_w);
            end
            blocks_sent++;
        end
        if (m_hs) begin
            if (keystream_q.size() == 0) begin
                $error("keystream item with no block pending: word_index %0d", m_tdata[3:0]);
                errors++;
            end else begin
                exp_w = keystream_q.pop_front();
                if (m_tdata[3:0] !== exp_w.idx) begin
                    $error("word_index mismatch: expected %0d, got %0d",
                           exp_w.idx, m_tdata[3:0]);
                    errors++;
                end
                if (m_tdata[35:4] !== exp_w.word) begin
                    $error("keystream_word mismatch: expected %08h, got %08h",
                           exp_w.word, m_tdata[35:4]);
                    errors++;
                end
                if (m_tlast !== exp_w.last) begin
                    $error("last_word mismatch: expected %0b, got %0b", exp_w.last, m_tlast);
                    errors++;
                end
                words_checked++;
            end
        end
        if (!aresetn || s_hs || m_hs || cfg_hs)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // counter driver: bursts with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_hs) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (counter_q.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= counter_q.pop_front();
                burst_left--;
                if (burst_left <= 0) begin
                    if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(16, 40);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 6);
                        gap_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 50)
                                                               : $urandom_range(0, 4);
                    end
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // keystream receiver stall pattern
    always @(negedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode = rx_mode_t'($urandom_range(0, 3));
            rdy_left = (rdy_mode == RX_HOLD) ? $urandom_range(1, 20) : $urandom_range(4, 60);
        end
        rdy_left--;
        case (rdy_mode)
            RX_FREE: m_tready <= 1'b1;
            RX_COIN: m_tready <= ($urandom_range(0, 1) != 0);
            RX_HOLD: m_tready <= 1'b0;
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    initial begin
        int p, r, n;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset key and nonce, counter extremes
        counter_q.push_back(32'h00000000);
        counter_q.push_back(32'h00000001);
        counter_q.push_back(32'hffffffff);
        counter_q.push_back(32'h80000000);
        counter_q.push_back(32'h55555555);
        counter_q.push_back(32'haaaaaaaa);
        wait_drained();

        // all ones; nonce word 2 gets excess high bits, spare indexes must be ignored
        write_reg(CFG_KEY_01, '1);
        write_reg(CFG_KEY_23, '1);
        write_reg(CFG_KEY_45, '1);
        write_reg(CFG_KEY_67, '1);
        write_reg(CFG_NONCE_01, '1);
        write_reg(CFG_NONCE_2, '1);
        write_reg(CFG_SPARE_6, {$urandom, $urandom});
        write_reg(CFG_SPARE_7, {$urandom, $urandom});
        counter_q.push_back(32'h00000000);
        counter_q.push_back(32'hffffffff);
        counter_q.push_back($urandom);
        counter_q.push_back($urandom);
        wait_drained();

        // rfc 8439 block test setting
        write_reg(CFG_KEY_01, 64'h07060504_03020100);
        write_reg(CFG_KEY_23, 64'h0f0e0d0c_0b0a0908);
        write_reg(CFG_KEY_45, 64'h17161514_13121110);
        write_reg(CFG_KEY_67, 64'h1f1e1d1c_1b1a1918);
        write_reg(CFG_NONCE_01, 64'h4a000000_09000000);
        write_reg(CFG_NONCE_2, 64'hdeadbeef_00000000);
        counter_q.push_back(32'h00000001);
        counter_q.push_back(32'h00000000);
        counter_q.push_back(32'h00000007);
        wait_drained();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            if ($urandom_range(0, 2) != 0) write_reg(CFG_KEY_01, pick_reg_value());
            if ($urandom_range(0, 2) != 0) write_reg(CFG_KEY_23, pick_reg_value());
            if ($urandom_range(0, 2) != 0) write_reg(CFG_KEY_45, pick_reg_value());
            if ($urandom_range(0, 2) != 0) write_reg(CFG_KEY_67, pick_reg_value());
            if ($urandom_range(0, 2) != 0) write_reg(CFG_NONCE_01, pick_reg_value());
            if ($urandom_range(0, 2) != 0) write_reg(CFG_NONCE_2, pick_reg_value());
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, pick_reg_value());
            n = $urandom_range(18, 30);
            for (r = 0; r < n; r++)
                counter_q.push_back(pick_counter());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d counter blocks over %0d key/nonce phases, %0d register writes",
                 blocks_sent, RANDOM_PHASES + 3, cfg_writes);
        $display("checked %0d keystream words with index and last flag, %0d errors",
                 words_checked, errors);
        if (errors == 0 && keystream_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
